/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/hwpm_pkg.sv */
package hwpm_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 12;
  localparam int POS_BITS    = $clog2(MAX_WINDOW);
  localparam int LEN_BITS    = POS_BITS + 1;
  localparam int CNT_BITS    = 2;
  localparam int MIN_WINDOW  = 2;
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(20);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Raw extremes of one finished window.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] max_a;
    logic [SAMPLE_BITS-1:0] max_b;
    logic [SAMPLE_BITS-1:0] min_a;
    logic [SAMPLE_BITS-1:0] min_b;
    logic [POS_BITS-1:0]    pos_max_a;
    logic [POS_BITS-1:0]    pos_max_b;
    logic [POS_BITS-1:0]    pos_min_a;
    logic [POS_BITS-1:0]    pos_min_b;
  } hwpm_rec_t;

  // One result item.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] first_max;
    logic [SAMPLE_BITS-1:0] second_max;
    logic [SAMPLE_BITS-1:0] first_min;
    logic [SAMPLE_BITS-1:0] second_min;
    logic [POS_BITS-1:0]    first_max_pos;
    logic [POS_BITS-1:0]    second_max_pos;
    logic [POS_BITS-1:0]    first_min_pos;
    logic [POS_BITS-1:0]    second_min_pos;
    logic [SAMPLE_BITS-1:0] swing;
    logic [SAMPLE_BITS-1:0] midpoint;
    logic [CNT_BITS-1:0]    peak_count;
    logic [CNT_BITS-1:0]    trough_count;
  } hwpm_res_t;

endpackage

/* rtl/core/hwpm_front.sv */
module hwpm_front import hwpm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [LEN_BITS-1:0]    window_length,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   rec_valid,
  input  logic                   rec_ready,
  output hwpm_rec_t              rec
);

  logic [POS_BITS-1:0] position;
  logic [POS_BITS-1:0] position_next;
  hwpm_rec_t           acc;
  hwpm_rec_t           acc_next;
  logic [LEN_BITS-1:0] len;
  logic [POS_BITS-1:0] half;
  logic                last;
  logic                accept;

  // Clamp the window length into its legal range.
  always_comb begin
    if (window_length < LEN_BITS'(MIN_WINDOW)) begin
      len = LEN_BITS'(MIN_WINDOW);
    end else if (window_length > LEN_BITS'(MAX_WINDOW)) begin
      len = LEN_BITS'(MAX_WINDOW);
    end else begin
      len = window_length;
    end
  end

  assign half      = POS_BITS'(len >> 1);
  assign last      = (LEN_BITS'(position) + LEN_BITS'(1)) >= len;
  assign in_ready  = !last || rec_ready;
  assign accept    = in_valid && in_ready;
  assign rec_valid = in_valid && last;
  assign rec       = acc_next;

  always_comb begin
    acc_next = acc;
    // Seed all four extremes on the first sample of a window.
    if (position == '0) begin
      acc_next.max_a     = sample;
      acc_next.max_b     = sample;
      acc_next.min_a     = sample;
      acc_next.min_b     = sample;
      acc_next.pos_max_a = '0;
      acc_next.pos_max_b = '0;
      acc_next.pos_min_a = '0;
      acc_next.pos_min_b = '0;
    end
    if (position <= half) begin
      if (sample > acc_next.max_a) begin
        acc_next.max_a     = sample;
        acc_next.pos_max_a = position;
      end
      if (sample < acc_next.min_a) begin
        acc_next.min_a     = sample;
        acc_next.pos_min_a = position;
      end
    end
    if (position >= half) begin
      if (sample > acc_next.max_b) begin
        acc_next.max_b     = sample;
        acc_next.pos_max_b = position;
      end
      if (sample < acc_next.min_b) begin
        acc_next.min_b     = sample;
        acc_next.pos_min_b = position;
      end
    end
    position_next = last ? '0 : position + POS_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= acc_next;
    end
  end

endmodule

/* rtl/core/hwpm_queue.sv */
module hwpm_queue import hwpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  hwpm_rec_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output hwpm_rec_t pop_data
);

  hwpm_rec_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = count != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/core/hwpm_back.sv */
module hwpm_back import hwpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      rec_valid,
  output logic      rec_ready,
  input  hwpm_rec_t rec,
  output logic      out_valid,
  input  logic      out_ready,
  output hwpm_res_t res
);

  hwpm_res_t              res_next;
  logic [CNT_BITS-1:0]    peaks;
  logic [CNT_BITS-1:0]    troughs;
  logic                   max_case;
  logic                   min_case;
  logic [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS-1:0] hi;
  logic [SAMPLE_BITS-1:0] lo;
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0] swing;
  logic [SAMPLE_BITS-1:0] half_swing;

  assign rec_ready = !out_valid || out_ready;

  always_comb begin
    peaks   = CNT_BITS'(rec.max_a != '0)
            + CNT_BITS'((rec.max_b != '0) && (rec.pos_max_a != rec.pos_max_b));
    troughs = CNT_BITS'(rec.min_a != '0)
            + CNT_BITS'((rec.min_b != '0) && (rec.pos_min_a != rec.pos_min_b));
    max_case = (peaks == CNT_BITS'(2)) && (troughs == CNT_BITS'(1));
    min_case = (peaks == CNT_BITS'(1)) && (troughs == CNT_BITS'(2));

    // Average the pair that was found twice; the other side is the lone extreme.
    if (max_case) begin
      sum = {1'b0, rec.max_a} + {1'b0, rec.max_b};
      hi  = sum[SAMPLE_BITS:1];
      lo  = rec.min_a;
    end else begin
      sum = {1'b0, rec.min_a} + {1'b0, rec.min_b};
      hi  = rec.max_b;
      lo  = sum[SAMPLE_BITS:1];
    end
    diff       = {1'b0, hi} - {1'b0, lo};
    swing      = diff[SAMPLE_BITS] ? '0 : diff[SAMPLE_BITS-1:0];
    half_swing = swing >> 1;

    res_next.first_max      = rec.max_a;
    res_next.second_max     = rec.max_b;
    res_next.first_min      = rec.min_a;
    res_next.second_min     = rec.min_b;
    res_next.first_max_pos  = rec.pos_max_a;
    res_next.second_max_pos = rec.pos_max_b;
    res_next.first_min_pos  = rec.pos_min_a;
    res_next.second_min_pos = rec.pos_min_b;
    res_next.peak_count     = peaks;
    res_next.trough_count   = troughs;
    res_next.swing          = '0;
    res_next.midpoint       = '0;
    if (max_case || min_case) begin
      res_next.swing    = swing;
      res_next.midpoint = (half_swing != '0) ? half_swing + lo : '0;
    end
    // Drop the extreme that the chosen case does not use.
    if (max_case) begin
      res_next.second_min     = '0;
      res_next.second_min_pos = '0;
    end
    if (min_case) begin
      res_next.first_max     = '0;
      res_next.first_max_pos = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_ready) begin
      out_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      res <= res_next;
    end
  end

endmodule

/* rtl/core/half_window_peak_midpoint_estimator_core.sv */
// Channel   Direction  Handshake            Payload
// config    in         cfg_we               cfg_data (window_length, 11 bits)
// samples   in         in_valid / in_ready  sample
// results   out        out_valid/out_ready  extremes, positions, swing, midpoint, counts
//
// One sample per cycle while in_ready is high; every sample is tracked by the front end.
// A window result leaves through the queue and then the back end's result register.
// A two-entry queue between front and back absorbs output stalls; in_ready drops only
// on a window's last sample while that queue is full.
// rst is synchronous, active high; it sets window_length to 20 and starts a new window.
`include "assert_macros.svh"

module half_window_peak_midpoint_estimator_core import hwpm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [LEN_BITS-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] first_max,
  output logic [SAMPLE_BITS-1:0] second_max,
  output logic [SAMPLE_BITS-1:0] first_min,
  output logic [SAMPLE_BITS-1:0] second_min,
  output logic [POS_BITS-1:0]    first_max_pos,
  output logic [POS_BITS-1:0]    second_max_pos,
  output logic [POS_BITS-1:0]    first_min_pos,
  output logic [POS_BITS-1:0]    second_min_pos,
  output logic [SAMPLE_BITS-1:0] swing,
  output logic [SAMPLE_BITS-1:0] midpoint,
  output logic [CNT_BITS-1:0]    peak_count,
  output logic [CNT_BITS-1:0]    trough_count
);

  logic [LEN_BITS-1:0] window_length;
  logic                push_valid;
  logic                push_ready;
  hwpm_rec_t           push_data;
  logic                pop_valid;
  logic                pop_ready;
  hwpm_rec_t           pop_data;
  hwpm_res_t           res;

  // Window length register; takes effect on the next sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_data;
    end
  end

  // Front end: track running extremes, emit one record per window.
  hwpm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .window_length (window_length),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .rec_valid     (push_valid),
    .rec_ready     (push_ready),
    .rec           (push_data)
  );

  // Hold finished windows while the result side stalls.
  hwpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: count extremes, derive swing and midpoint, register the result.
  hwpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (pop_valid),
    .rec_ready (pop_ready),
    .rec       (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign first_max      = res.first_max;
  assign second_max     = res.second_max;
  assign first_min      = res.first_min;
  assign second_min     = res.second_min;
  assign first_max_pos  = res.first_max_pos;
  assign second_max_pos = res.second_max_pos;
  assign first_min_pos  = res.first_min_pos;
  assign second_min_pos = res.second_min_pos;
  assign swing          = res.swing;
  assign midpoint       = res.midpoint;
  assign peak_count     = res.peak_count;
  assign trough_count   = res.trough_count;

  // Input stalls only when the queue cannot take a finished window.
  `ASSERT_IMPL(a_stall_only_full, !in_ready, !push_ready)
  // Counts never exceed two.
  `ASSERT_IMPL(a_count_range, out_valid,
               (peak_count != CNT_BITS'(3)) && (trough_count != CNT_BITS'(3)))
  // Maxima case reports no second minimum.
  `ASSERT_IMPL(a_max_case_zero,
               out_valid && (peak_count == CNT_BITS'(2)) && (trough_count == CNT_BITS'(1)),
               (second_min == '0) && (second_min_pos == '0))
  // A swing under two leaves no midpoint.
  `ASSERT_IMPL(a_small_swing, out_valid && (swing < SAMPLE_BITS'(2)), midpoint == '0)

endmodule

/* tb/tb_half_window_peak_midpoint_estimator_core.sv */
`default_nettype none

module tb_half_window_peak_midpoint_estimator_core;
  import hwpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Rough number of samples to push through the block.
  localparam int unsigned ITEM_TARGET = 1950;
  // Receiver hold-off used once to back the block up into its input.
  localparam int unsigned HOLD_CYCLES = 300;
  // Cycles to let the block settle before a length write or the end.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 20;
  // Samples at the end of the run sent with no idling. One pass of the main
  // loop sends at most 8 * 40 + 39 samples, so the last pass always starts
  // inside this tail.
  localparam int unsigned QUIET_TAIL = 400;

  // Window lengths worth naming: below the floor, the floor, the ceiling
  // and the largest value the register can hold.
  localparam logic [LEN_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LEN_BITS-1:0] LEN_ONE  = LEN_BITS'(1);
  localparam logic [LEN_BITS-1:0] LEN_MIN  = LEN_BITS'(MIN_WINDOW);
  localparam logic [LEN_BITS-1:0] LEN_MAX  = LEN_BITS'(MAX_WINDOW);
  localparam logic [LEN_BITS-1:0] LEN_ALL  = '1;

  // Shape of the samples in one random window.
  typedef enum int {
    WAVE_UNIFORM,
    WAVE_LEVELS,
    WAVE_SPARSE,
    WAVE_TRIANGLE,
    WAVE_NOISY
  } wave_style_e;

  // Tracks the four running extremes the way the block should, and keeps
  // the window summaries that are still owed by the output channel.
  class midpoint_scoreboard;
    logic [LEN_BITS-1:0]    win_len_reg;
    int unsigned            idx;
    logic [SAMPLE_BITS-1:0] hi_a, hi_b, lo_a, lo_b;
    logic [POS_BITS-1:0]    pos_hi_a, pos_hi_b, pos_lo_a, pos_lo_b;
    hwpm_res_t              window_results_q[$];
    int unsigned            errors;

    function new();
      win_len_reg = LEN_RESET;
      idx = 0;
      {hi_a, hi_b, lo_a, lo_b} = '0;
      {pos_hi_a, pos_hi_b, pos_lo_a, pos_lo_b} = '0;
      errors = 0;
    endfunction

    function void write_length(logic [LEN_BITS-1:0] v);
      win_len_reg = v;
    endfunction

    // Length in effect, clamped to the legal window range.
    function int unsigned span();
      int unsigned n;
      n = win_len_reg;
      if (n < MIN_WINDOW) n = MIN_WINDOW;
      if (n > MAX_WINDOW) n = MAX_WINDOW;
      return n;
    endfunction

    function int unsigned pending();
      return window_results_q.size();
    endfunction

    function hwpm_res_t summarize();
      hwpm_res_t   r;
      int unsigned peaks, troughs;
      int          avg, dlt, mid;
      r.first_max      = hi_a;
      r.second_max     = hi_b;
      r.first_min      = lo_a;
      r.second_min     = lo_b;
      r.first_max_pos  = pos_hi_a;
      r.second_max_pos = pos_hi_b;
      r.first_min_pos  = pos_lo_a;
      r.second_min_pos = pos_lo_b;
      peaks = 0;
      troughs = 0;
      dlt = 0;
      mid = 0;
      if (hi_a != 0) peaks++;
      if (hi_b != 0 && pos_hi_a != pos_hi_b) peaks++;
      if (lo_a != 0) troughs++;
      if (lo_b != 0 && pos_lo_a != pos_lo_b) troughs++;
      if (peaks == 2 && troughs == 1) begin
        r.second_min = '0;
        r.second_min_pos = '0;
        avg = (int'(hi_a) + int'(hi_b)) >> 1;
        dlt = avg - int'(lo_a);
        if (dlt < 0) dlt = 0;
        mid = dlt >> 1;
        if (mid != 0) mid += int'(lo_a);
      end else if (peaks == 1 && troughs == 2) begin
        r.first_max = '0;
        r.first_max_pos = '0;
        avg = (int'(lo_a) + int'(lo_b)) >> 1;
        dlt = int'(hi_b) - avg;
        if (dlt < 0) dlt = 0;
        mid = dlt >> 1;
        if (mid != 0) mid += avg;
      end
      r.swing        = SAMPLE_BITS'(dlt);
      r.midpoint     = SAMPLE_BITS'(mid);
      r.peak_count   = CNT_BITS'(peaks);
      r.trough_count = CNT_BITS'(troughs);
      return r;
    endfunction

    function void take_sample(logic [SAMPLE_BITS-1:0] s);
      int unsigned n, half;
      n = span();
      half = n >> 1;
      if (idx == 0) begin
        {hi_a, hi_b, lo_a, lo_b} = {s, s, s, s};
        {pos_hi_a, pos_hi_b, pos_lo_a, pos_lo_b} = '0;
      end
      if (idx <= half) begin
        if (s > hi_a) begin
          hi_a = s;
          pos_hi_a = POS_BITS'(idx);
        end
        if (s < lo_a) begin
          lo_a = s;
          pos_lo_a = POS_BITS'(idx);
        end
      end
      if (idx >= half) begin
        if (s > hi_b) begin
          hi_b = s;
          pos_hi_b = POS_BITS'(idx);
        end
        if (s < lo_b) begin
          lo_b = s;
          pos_lo_b = POS_BITS'(idx);
        end
      end
      if (idx + 1 >= n) begin
        window_results_q.push_back(summarize());
        idx = 0;
      end else begin
        idx++;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void match_window(hwpm_res_t got);
      hwpm_res_t want;
      if (window_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = window_results_q.pop_front();
      compare_field("first_max", want.first_max, got.first_max);
      compare_field("second_max", want.second_max, got.second_max);
      compare_field("first_min", want.first_min, got.first_min);
      compare_field("second_min", want.second_min, got.second_min);
      compare_field("first_max_pos", want.first_max_pos, got.first_max_pos);
      compare_field("second_max_pos", want.second_max_pos, got.second_max_pos);
      compare_field("first_min_pos", want.first_min_pos, got.first_min_pos);
      compare_field("second_min_pos", want.second_min_pos, got.second_min_pos);
      compare_field("swing", want.swing, got.swing);
      compare_field("midpoint", want.midpoint, got.midpoint);
      compare_field("peak_count", want.peak_count, got.peak_count);
      compare_field("trough_count", want.trough_count, got.trough_count);
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [LEN_BITS-1:0]    cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] first_max, second_max, first_min, second_min;
  logic [POS_BITS-1:0]    first_max_pos, second_max_pos, first_min_pos, second_min_pos;
  logic [SAMPLE_BITS-1:0] swing, midpoint;
  logic [CNT_BITS-1:0]    peak_count, trough_count;

  midpoint_scoreboard sb = new();

  // Idle controls shared between the sender and the receiver.
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned sent = 0;

  half_window_peak_midpoint_estimator_core dut (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid, .in_ready, .sample,
    .out_valid, .out_ready,
    .first_max, .second_max, .first_min, .second_min,
    .first_max_pos, .second_max_pos, .first_min_pos, .second_min_pos,
    .swing, .midpoint, .peak_count, .trough_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one sample and hold it until the transfer happens. Valid stays high
  // between back-to-back samples; only a random gap drops it.
  task automatic offer_sample(input logic [SAMPLE_BITS-1:0] s);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    sb.take_sample(s);
    sent++;
  endtask

  // Drop valid, let every owed window drain, then write the length register.
  // Any partial window stays open, so the new length hits it mid-window.
  task automatic set_length(input logic [LEN_BITS-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_length(v);
  endtask

  // Send count samples shaped over a window of n. Triangles over one window
  // give the clean one-peak / two-trough or two-peak / one-trough patterns;
  // levels and sparse windows give ties and zero extremes for the counting rules.
  task automatic send_samples(input int unsigned n, input int unsigned count);
    wave_style_e style;
    int          base, amp, phase, halfp, t, v;
    int          levels [5] = '{0, 1, 2048, 4094, 4095};
    style = wave_style_e'($urandom_range(0, 4));
    base  = $urandom_range(0, 2047);
    amp   = $urandom_range(0, 4095 - base);
    phase = $urandom_range(0, n - 1);
    halfp = n >> 1;
    for (int k = 0; k < count; k++) begin
      case (style)
        WAVE_UNIFORM: v = $urandom_range(0, 4095);
        WAVE_LEVELS:  v = levels[$urandom_range(0, 4)];
        WAVE_SPARSE:  v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0;
        default: begin
          t = (k + phase) % n;
          if (t > halfp) t = n - t;
          v = base + amp * t / halfp;
          if (style == WAVE_NOISY) v = v + int'($urandom_range(0, 32)) - 16;
        end
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      offer_sample(SAMPLE_BITS'(v));
    end
  endtask

  // Result side: check each transfer, then pick the next ready level. The
  // long hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin : result_sink
    int unsigned stall_left;
    hwpm_res_t   got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = '{first_max: first_max, second_max: second_max,
                first_min: first_min, second_min: second_min,
                first_max_pos: first_max_pos, second_max_pos: second_max_pos,
                first_min_pos: first_min_pos, second_min_pos: second_min_pos,
                swing: swing, midpoint: midpoint,
                peak_count: peak_count, trough_count: trough_count};
        sb.match_window(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    // Reset length: eight samples, then a shorter length closes the window
    // on the very next sample.
    logic [SAMPLE_BITS-1:0] opening [8] = '{12'd100, 12'd4095, 12'd0, 12'd50,
                                            12'd200, 12'd4095, 12'd0, 12'd300};
    // Two maxima in separate halves, the minimum on the middle sample.
    logic [SAMPLE_BITS-1:0] two_peaks [5] = '{12'd10, 12'd3000, 12'd5, 12'd2900, 12'd7};
    // Maximum on the middle sample, one trough in each half.
    logic [SAMPLE_BITS-1:0] two_troughs [5] = '{12'd2000, 12'd100, 12'd3000, 12'd200,
                                                12'd3000};
    int unsigned n;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[k]) offer_sample(opening[k]);
    set_length(LEN_BITS'(5));
    offer_sample(12'd4000);

    // Lengths below the floor behave as two; all-zero and full-scale windows.
    set_length(LEN_ZERO);
    offer_sample(12'd0);
    offer_sample(12'd0);
    offer_sample(12'd4095);
    offer_sample(12'd4094);
    set_length(LEN_ONE);
    offer_sample(12'h555);
    offer_sample(12'hAAA);

    set_length(LEN_BITS'(5));
    foreach (two_peaks[k]) offer_sample(two_peaks[k]);
    foreach (two_troughs[k]) offer_sample(two_troughs[k]);

    // Short windows with the receiver held off: results pile up and the
    // block has to stall its input.
    set_length(LEN_BITS'(4));
    hold_req = 1'b1;
    repeat (60) send_samples(4, 4);

    // Largest register value clamps to the ceiling; then leave a window at
    // the ceiling open and let the next length write cut it short.
    set_length(LEN_ALL);
    send_samples(sb.span(), sb.span());
    set_length(LEN_MAX);
    send_samples(sb.span(), 30);

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       set_length(LEN_MIN);
        1:       set_length(LEN_BITS'(3));
        default: set_length(LEN_BITS'($urandom_range(4, 40)));
      endcase
      // Keep the tail of the run free of idling on both sides.
      if (sent > ITEM_TARGET - QUIET_TAIL) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else begin
        tx_gaps = ($urandom_range(0, 2) != 0);
        rx_gaps = ($urandom_range(0, 2) != 0);
      end
      n = sb.span();
      repeat ($urandom_range(2, 8)) send_samples(n, n);
      if ($urandom_range(0, 5) == 0) send_samples(n, $urandom_range(1, n - 1));
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
